[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker modules of the rotate core.
// Needs clk and rst in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EVR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("evr check failed");

// Next-cycle implication, disabled during reset.
`define EVR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("evr check failed");

`endif

[rtl/core/evr_pkg.sv]
// Shared widths, constants, types and helpers of the Euler vector rotate core.
// No dependencies; every other file of the core but assert_macros.svh refers to it by scoped names.
package evr_pkg;

  // Component and angle widths
  localparam int CW = 32;
  localparam int AB = 16;

  // Q2.30 trig values, matrix entries, dot product widths
  localparam int QW = 32;
  localparam int MW = QW + 1;
  localparam int PW = CW + MW;
  localparam int SW = PW + 2;
  localparam int HALF_LSB = 536870912;

  localparam logic [30:0] HALF_PI = 31'd1686629713;
  localparam logic signed [QW-1:0] Q_ONE = 32'sh4000_0000;

  // Series steps and pipeline depths
  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int HORNER_LAT = 4;
  localparam int SIN_PAD = (COS_STEPS - SIN_STEPS) * HORNER_LAT - 2;
  localparam int SC_LAT = 4 + COS_STEPS * HORNER_LAT + 1;
  localparam int MAT_LAT = 4;
  localparam int VEC_DLY = SC_LAT + MAT_LAT;

  // Series divisors and their 2^32 reciprocals
  localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
    32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
    32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)};
  localparam logic [7:0] COS_DIV [COS_STEPS] =
    '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_RCP [COS_STEPS] = '{
    32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
    32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)};

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  // Side data that rides along the series pipeline
  typedef struct packed {
    logic [30:0] x;
    quad_t       quad;
  } sc_tag_t;

  typedef logic signed [MW-1:0] ment_t;

  // Round a Q4.60 product to Q2.30, half up
  function automatic logic signed [QW-1:0] round_q30(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = (v + 64'sd536870912) >>> 30;
    return w[QW-1:0];
  endfunction

endpackage

[rtl/core/evr_horner.sv]
// One Horner step of the sine/cosine series: h_o = 1 - round(x2*h_i) / div.
// Four register stages; uses evr_pkg for the tag type and the Q2.30 one.
module evr_horner (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [7:0]                div,
  input  logic [31:0]               rcp,
  input  logic [31:0]               x2_i,
  input  logic signed [31:0]        h_i,
  input  evr_pkg::sc_tag_t          tag_i,
  output logic                      valid_o,
  output logic [31:0]               x2_o,
  output logic signed [31:0]        h_o,
  output evr_pkg::sc_tag_t          tag_o
);

  logic              v_a, v_b, v_c;
  logic [31:0]       x2_a, x2_b, x2_c;
  evr_pkg::sc_tag_t  tag_a, tag_b, tag_c;
  logic signed [64:0] prod_a;
  logic [31:0]       p_b, p_c;
  logic [63:0]       m_c;

  logic signed [64:0] rnd_b;
  logic [31:0]       q0_d, q_d;
  logic [39:0]       qd_d, r_d;

  // Round the product, then fix the reciprocal quotient by one compare
  always_comb begin
    rnd_b = (prod_a + 65'sd536870912) >>> 30;
    q0_d  = m_c[63:32];
    qd_d  = {8'd0, q0_d} * {32'd0, div};
    r_d   = {8'd0, p_c} - qd_d;
    q_d   = q0_d + {31'd0, (r_d >= {32'd0, div})};
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a     <= 1'b0;
      v_b     <= 1'b0;
      v_c     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v_a     <= valid_i;
      v_b     <= v_a;
      v_c     <= v_b;
      valid_o <= v_c;
    end
  end

  // Advance data: multiply, round, reciprocal multiply, correct
  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= $signed({1'b0, x2_i}) * h_i;
      x2_a   <= x2_i;
      tag_a  <= tag_i;
      p_b    <= rnd_b[31:0];
      x2_b   <= x2_a;
      tag_b  <= tag_a;
      m_c    <= {32'd0, p_b} * {32'd0, rcp};
      p_c    <= p_b;
      x2_c   <= x2_b;
      tag_c  <= tag_b;
      h_o    <= evr_pkg::Q_ONE - $signed(q_d);
      x2_o   <= x2_c;
      tag_o  <= tag_c;
    end
  end

endmodule

[rtl/core/evr_sincos.sv]
// Pipelined sine and cosine of one binary angle, Q2.30 out.
// Uses evr_pkg and instantiates evr_horner for each series step.
module evr_sincos (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [evr_pkg::AB-1:0]    angle,
  output logic                      valid_o,
  output logic signed [31:0]        s_o,
  output logic signed [31:0]        c_o
);

  logic [29:0]       frac;
  logic              v0, v1, v2, v3;
  logic [60:0]       xp0;
  evr_pkg::quad_t    quad0, quad1, quad2;
  logic [30:0]       x1, x2s;
  logic [61:0]       xx2;
  logic [31:0]       x2_3;
  evr_pkg::sc_tag_t  tag3;
  logic [60:0]       x_rnd;
  logic [61:0]       xx_rnd;

  logic              cos_v   [evr_pkg::COS_STEPS+1];
  logic [31:0]       cos_x2  [evr_pkg::COS_STEPS+1];
  logic signed [31:0] cos_h  [evr_pkg::COS_STEPS+1];
  evr_pkg::sc_tag_t  cos_tag [evr_pkg::COS_STEPS+1];
  logic              sin_v   [evr_pkg::SIN_STEPS+1];
  logic [31:0]       sin_x2  [evr_pkg::SIN_STEPS+1];
  logic signed [31:0] sin_h  [evr_pkg::SIN_STEPS+1];
  evr_pkg::sc_tag_t  sin_tag [evr_pkg::SIN_STEPS+1];

  logic              sv_a, sv_b;
  logic signed [63:0] sp_a;
  logic signed [31:0] s_b;
  logic              sv_dly [evr_pkg::SIN_PAD];
  logic signed [31:0] s_dly [evr_pkg::SIN_PAD];
  logic signed [31:0] s_cl, c_cl;

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > evr_pkg::Q_ONE) r = evr_pkg::Q_ONE;
    return r;
  endfunction

  // Scale the in-quadrant bits to Q0.30
  assign frac = {angle[evr_pkg::AB-3:0], {(32 - evr_pkg::AB){1'b0}}};

  always_comb begin
    x_rnd  = xp0 + 61'd536870912;
    xx_rnd = xx2 + 62'd536870912;
  end

  // Advance valid bits of the argument stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= valid_i;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Form x = t*pi/2 and x^2, rounding each product
  always_ff @(posedge clk) begin
    if (en) begin
      xp0   <= {31'd0, frac} * {30'd0, evr_pkg::HALF_PI};
      quad0 <= evr_pkg::quad_t'(angle[evr_pkg::AB-1:evr_pkg::AB-2]);
      x1    <= x_rnd[60:30];
      quad1 <= quad0;
      xx2   <= {31'd0, x1} * {31'd0, x1};
      x2s   <= x1;
      quad2 <= quad1;
      x2_3  <= xx_rnd[61:30];
      tag3  <= '{x: x2s, quad: quad2};
    end
  end

  assign cos_v[0]   = v3;
  assign cos_x2[0]  = x2_3;
  assign cos_h[0]   = evr_pkg::Q_ONE;
  assign cos_tag[0] = tag3;
  assign sin_v[0]   = v3;
  assign sin_x2[0]  = x2_3;
  assign sin_h[0]   = evr_pkg::Q_ONE;
  assign sin_tag[0] = tag3;

  for (genvar i = 0; i < evr_pkg::COS_STEPS; i++) begin : g_cos
    evr_horner u_step (
      .clk(clk), .rst(rst), .en(en), .valid_i(cos_v[i]),
      .div(evr_pkg::COS_DIV[i]), .rcp(evr_pkg::COS_RCP[i]),
      .x2_i(cos_x2[i]), .h_i(cos_h[i]), .tag_i(cos_tag[i]),
      .valid_o(cos_v[i+1]), .x2_o(cos_x2[i+1]), .h_o(cos_h[i+1]), .tag_o(cos_tag[i+1])
    );
  end

  for (genvar i = 0; i < evr_pkg::SIN_STEPS; i++) begin : g_sin
    evr_horner u_step (
      .clk(clk), .rst(rst), .en(en), .valid_i(sin_v[i]),
      .div(evr_pkg::SIN_DIV[i]), .rcp(evr_pkg::SIN_RCP[i]),
      .x2_i(sin_x2[i]), .h_i(sin_h[i]), .tag_i(sin_tag[i]),
      .valid_o(sin_v[i+1]), .x2_o(sin_x2[i+1]), .h_o(sin_h[i+1]), .tag_o(sin_tag[i+1])
    );
  end

  // Advance valid bits of the sine tail
  always_ff @(posedge clk) begin
    if (rst) begin
      sv_a <= 1'b0;
      sv_b <= 1'b0;
      for (int i = 0; i < evr_pkg::SIN_PAD; i++) sv_dly[i] <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      sv_a      <= sin_v[evr_pkg::SIN_STEPS];
      sv_b      <= sv_a;
      sv_dly[0] <= sv_b;
      for (int i = 1; i < evr_pkg::SIN_PAD; i++) sv_dly[i] <= sv_dly[i-1];
      valid_o   <= sv_dly[evr_pkg::SIN_PAD-1] & cos_v[evr_pkg::COS_STEPS];
    end
  end

  // Multiply the sine series by x, then hold to line up with cosine
  always_ff @(posedge clk) begin
    if (en) begin
      sp_a     <= $signed({1'b0, sin_tag[evr_pkg::SIN_STEPS].x}) * sin_h[evr_pkg::SIN_STEPS];
      s_b      <= evr_pkg::round_q30(sp_a);
      s_dly[0] <= s_b;
      for (int i = 1; i < evr_pkg::SIN_PAD; i++) s_dly[i] <= s_dly[i-1];
    end
  end

  assign s_cl = clamp_q(s_dly[evr_pkg::SIN_PAD-1]);
  assign c_cl = clamp_q(cos_h[evr_pkg::COS_STEPS]);

  // Map the first-quadrant pair to the angle's quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (cos_tag[evr_pkg::COS_STEPS].quad)
        evr_pkg::QUAD_0: begin s_o <= s_cl;  c_o <= c_cl;  end
        evr_pkg::QUAD_1: begin s_o <= c_cl;  c_o <= -s_cl; end
        evr_pkg::QUAD_2: begin s_o <= -s_cl; c_o <= -c_cl; end
        default:         begin s_o <= -c_cl; c_o <= s_cl;  end
      endcase
    end
  end

endmodule

[rtl/core/evr_matrix.sv]
// Rotation matrix rows (forward, side, up) from three sine/cosine pairs.
// Four register stages; uses evr_pkg for widths and Q2.30 rounding.
module evr_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_i,
  input  logic signed [31:0]  sp,
  input  logic signed [31:0]  cp,
  input  logic signed [31:0]  sy,
  input  logic signed [31:0]  cy,
  input  logic signed [31:0]  sr,
  input  logic signed [31:0]  cr,
  output logic                valid_o,
  output evr_pkg::ment_t      fwd_o  [3],
  output evr_pkg::ment_t      side_o [3],
  output evr_pkg::ment_t      up_o   [3]
);

  logic              v_a, v_b, v_c;
  logic signed [63:0] r_srsp, r_crsp, r_cpcy, r_cpsy, r_crsy, r_crcy, r_srcp, r_srsy;
  logic signed [63:0] r_srcy, r_crcp;
  logic signed [31:0] cy_a, sy_a, sp_a, cy_b, sy_b, sp_b, sp_c;
  logic signed [31:0] t1, t2, cpcy, cpsy, crsy, crcy, srcp, srsy, srcy, crcp;
  logic signed [31:0] cpcy_c, cpsy_c, crsy_c, crcy_c, srcp_c, srsy_c, srcy_c, crcp_c;
  logic signed [63:0] r_t1cy, r_t1sy, r_t2cy, r_t2sy;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a     <= 1'b0;
      v_b     <= 1'b0;
      v_c     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v_a     <= valid_i;
      v_b     <= v_a;
      v_c     <= v_b;
      valid_o <= v_c;
    end
  end

  // Pair products, round, triple products, combine
  always_ff @(posedge clk) begin
    if (en) begin
      r_srsp <= sr * sp;
      r_crsp <= cr * sp;
      r_cpcy <= cp * cy;
      r_cpsy <= cp * sy;
      r_crsy <= cr * sy;
      r_crcy <= cr * cy;
      r_srcp <= sr * cp;
      r_srsy <= sr * sy;
      r_srcy <= sr * cy;
      r_crcp <= cr * cp;
      cy_a   <= cy;
      sy_a   <= sy;
      sp_a   <= sp;

      t1   <= evr_pkg::round_q30(r_srsp);
      t2   <= evr_pkg::round_q30(r_crsp);
      cpcy <= evr_pkg::round_q30(r_cpcy);
      cpsy <= evr_pkg::round_q30(r_cpsy);
      crsy <= evr_pkg::round_q30(r_crsy);
      crcy <= evr_pkg::round_q30(r_crcy);
      srcp <= evr_pkg::round_q30(r_srcp);
      srsy <= evr_pkg::round_q30(r_srsy);
      srcy <= evr_pkg::round_q30(r_srcy);
      crcp <= evr_pkg::round_q30(r_crcp);
      cy_b <= cy_a;
      sy_b <= sy_a;
      sp_b <= sp_a;

      r_t1cy <= t1 * cy_b;
      r_t1sy <= t1 * sy_b;
      r_t2cy <= t2 * cy_b;
      r_t2sy <= t2 * sy_b;
      cpcy_c <= cpcy;
      cpsy_c <= cpsy;
      crsy_c <= crsy;
      crcy_c <= crcy;
      srcp_c <= srcp;
      srsy_c <= srsy;
      srcy_c <= srcy;
      crcp_c <= crcp;
      sp_c   <= sp_b;

      fwd_o[0]  <= 33'(cpcy_c);
      fwd_o[1]  <= 33'(cpsy_c);
      fwd_o[2]  <= -33'(sp_c);
      side_o[0] <= 33'(evr_pkg::round_q30(r_t1cy)) - 33'(crsy_c);
      side_o[1] <= 33'(evr_pkg::round_q30(r_t1sy)) + 33'(crcy_c);
      side_o[2] <= 33'(srcp_c);
      up_o[0]   <= 33'(evr_pkg::round_q30(r_t2cy)) + 33'(srsy_c);
      up_o[1]   <= 33'(evr_pkg::round_q30(r_t2sy)) - 33'(srcy_c);
      up_o[2]   <= 33'(crcp_c);
    end
  end

endmodule

[rtl/core/evr_dot.sv]
// Dot product of the vector with one matrix row, rounded and saturated.
// Four register stages; uses evr_pkg for widths.
module evr_dot (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_i,
  input  logic signed [evr_pkg::CW-1:0] v_i [3],
  input  evr_pkg::ment_t             row_i [3],
  output logic                       valid_o,
  output logic signed [evr_pkg::CW-1:0] r_o
);

  logic                          v_a, v_b, v_c;
  logic signed [evr_pkg::PW-1:0] prod [3];
  logic signed [evr_pkg::PW-1:0] p2_b;
  logic signed [evr_pkg::SW-1:0] s01_b, sum_c, rr;
  logic                          in_range;

  // Round half up, then check that the top bits are a sign extension
  always_comb begin
    rr       = (sum_c + evr_pkg::SW'(evr_pkg::HALF_LSB)) >>> 30;
    in_range = (&rr[evr_pkg::SW-1:evr_pkg::CW-1]) | ~(|rr[evr_pkg::SW-1:evr_pkg::CW-1]);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a     <= 1'b0;
      v_b     <= 1'b0;
      v_c     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v_a     <= valid_i;
      v_b     <= v_a;
      v_c     <= v_b;
      valid_o <= v_c;
    end
  end

  // Multiply, add in two steps, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) prod[i] <= v_i[i] * row_i[i];
      s01_b <= evr_pkg::SW'(prod[0]) + evr_pkg::SW'(prod[1]);
      p2_b  <= prod[2];
      sum_c <= s01_b + evr_pkg::SW'(p2_b);
      if (in_range) r_o <= rr[evr_pkg::CW-1:0];
      else if (rr[evr_pkg::SW-1]) r_o <= {1'b1, {(evr_pkg::CW-1){1'b0}}};
      else r_o <= {1'b0, {(evr_pkg::CW-1){1'b1}}};
    end
  end

endmodule

[rtl/core/euler_vector_rotate_core.sv]
// Top level of the Euler vector rotate core: sine/cosine, matrix, dot pipelines.
// Uses evr_pkg, evr_sincos, evr_matrix and evr_dot.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_stall, in_x/y/z,         | into core
//           | pitch, yaw, roll                      |
//   output  | out_valid, out_stall, out_x/y/z       | out of core
//
// One item per cycle sustained while in_stall is low; each result passes the
// sine/cosine series, the matrix, the dot products and the output register in that order.
// The longest run is the seven-step cosine series, four stages per step.
// rst clears all valid bits; payload registers are not reset.
// A stalled output parks one result in a skid register and then holds
// in_stall high until the output register drains.
module euler_vector_rotate_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [evr_pkg::CW-1:0] in_x,
  input  logic signed [evr_pkg::CW-1:0] in_y,
  input  logic signed [evr_pkg::CW-1:0] in_z,
  input  logic [evr_pkg::AB-1:0]        pitch,
  input  logic [evr_pkg::AB-1:0]        yaw,
  input  logic [evr_pkg::AB-1:0]        roll,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [evr_pkg::CW-1:0] out_x,
  output logic signed [evr_pkg::CW-1:0] out_y,
  output logic signed [evr_pkg::CW-1:0] out_z
);

  logic en, accept;
  logic skid_valid;
  logic signed [evr_pkg::CW-1:0] skid_x, skid_y, skid_z;

  logic vp, vy, vr, mv;
  logic signed [31:0] sp, cp, sy, cy, sr, cr;
  evr_pkg::ment_t fwd [3];
  evr_pkg::ment_t side [3];
  evr_pkg::ment_t up [3];

  logic signed [evr_pkg::CW-1:0] vx_dly [evr_pkg::VEC_DLY];
  logic signed [evr_pkg::CW-1:0] vy_dly [evr_pkg::VEC_DLY];
  logic signed [evr_pkg::CW-1:0] vz_dly [evr_pkg::VEC_DLY];
  logic signed [evr_pkg::CW-1:0] vec [3];

  logic dv0, dv1, dv2, tail_valid;
  logic signed [evr_pkg::CW-1:0] rx, ry, rz;

  // Pipeline advances whenever the skid register is free
  assign en       = ~skid_valid;
  assign in_stall = skid_valid;
  assign accept   = in_valid & ~in_stall;

  evr_sincos u_sc_pitch (.clk(clk), .rst(rst), .en(en), .valid_i(accept), .angle(pitch),
                         .valid_o(vp), .s_o(sp), .c_o(cp));
  evr_sincos u_sc_yaw   (.clk(clk), .rst(rst), .en(en), .valid_i(accept), .angle(yaw),
                         .valid_o(vy), .s_o(sy), .c_o(cy));
  evr_sincos u_sc_roll  (.clk(clk), .rst(rst), .en(en), .valid_i(accept), .angle(roll),
                         .valid_o(vr), .s_o(sr), .c_o(cr));

  evr_matrix u_matrix (
    .clk(clk), .rst(rst), .en(en), .valid_i(vp & vy & vr),
    .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
    .valid_o(mv), .fwd_o(fwd), .side_o(side), .up_o(up)
  );

  // Hold the vector until its matrix is ready
  always_ff @(posedge clk) begin
    if (en) begin
      vx_dly[0] <= in_x;
      vy_dly[0] <= in_y;
      vz_dly[0] <= in_z;
      for (int i = 1; i < evr_pkg::VEC_DLY; i++) begin
        vx_dly[i] <= vx_dly[i-1];
        vy_dly[i] <= vy_dly[i-1];
        vz_dly[i] <= vz_dly[i-1];
      end
    end
  end

  assign vec[0] = vx_dly[evr_pkg::VEC_DLY-1];
  assign vec[1] = vy_dly[evr_pkg::VEC_DLY-1];
  assign vec[2] = vz_dly[evr_pkg::VEC_DLY-1];

  evr_dot u_dot_fwd  (.clk(clk), .rst(rst), .en(en), .valid_i(mv), .v_i(vec), .row_i(fwd),
                      .valid_o(dv0), .r_o(rx));
  evr_dot u_dot_side (.clk(clk), .rst(rst), .en(en), .valid_i(mv), .v_i(vec), .row_i(side),
                      .valid_o(dv1), .r_o(ry));
  evr_dot u_dot_up   (.clk(clk), .rst(rst), .en(en), .valid_i(mv), .v_i(vec), .row_i(up),
                      .valid_o(dv2), .r_o(rz));

  assign tail_valid = dv0 & dv1 & dv2;

  // Output and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~out_valid | ~out_stall) begin
      out_valid  <= skid_valid | tail_valid;
      skid_valid <= 1'b0;
    end else if (tail_valid & ~skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid data
  always_ff @(posedge clk) begin
    if (~out_valid | ~out_stall) begin
      if (skid_valid) begin
        out_x <= skid_x;
        out_y <= skid_y;
        out_z <= skid_z;
      end else begin
        out_x <= rx;
        out_y <= ry;
        out_z <= rz;
      end
    end else if (~skid_valid) begin
      skid_x <= rx;
      skid_y <= ry;
      skid_z <= rz;
    end
  end

endmodule

[rtl/core/evr_check.sv]
// Port-level checks of the rotate core's output register and skid stage.
// Uses assert_macros.svh and evr_pkg; bound to euler_vector_rotate_core.
module evr_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [evr_pkg::CW-1:0] out_x,
  input logic signed [evr_pkg::CW-1:0] out_y,
  input logic signed [evr_pkg::CW-1:0] out_z
);

`include "assert_macros.svh"

  // A stalled result holds
  `EVR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))

  // Input back-pressure only while a result is on the output
  `EVR_ASSERT_NOW(a_stall_has_out, in_stall || !in_valid || in_valid, !in_stall || out_valid)

  // Back-pressure starts only after a stalled output
  `EVR_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

  // A free output drains the skid stage
  `EVR_ASSERT_NEXT(a_skid_drain, out_valid && !out_stall, !in_stall)

endmodule

bind euler_vector_rotate_core evr_check u_evr_check (.*);

[sim/tb_euler_vector_rotate_core.sv]
// Self-checking testbench for euler_vector_rotate_core: fixed-point Euler rotation of Q16.16 vectors.
// Depends on evr_pkg and the core RTL; holds its own predictor and a small result scoreboard.
module tb_euler_vector_rotate_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rot_vec_t;

  // Predict rotated vectors and compare them in transfer order
  class rotation_scoreboard;
    rot_vec_t pending[$];
    int errors;
    int matched;
    longint sin_div[6] = '{156, 110, 72, 42, 20, 6};
    longint cos_div[7] = '{182, 132, 90, 56, 30, 12, 2};

    function longint q30(longint v);
      return (v + 64'sd536870912) >>> 30;
    endfunction

    function void sin_cos(logic [15:0] ang, output longint s, output longint c);
      longint frac, x, x2, h, ss, cc;
      evr_pkg::quad_t quad;
      quad = evr_pkg::quad_t'(ang[15:14]);
      frac = longint'(ang[13:0]) << 16;
      x = q30(frac * 64'sd1686629713);
      x2 = q30(x * x);
      h = 64'sd1 << 30;
      for (int i = 0; i < 6; i++) h = (64'sd1 << 30) - q30(x2 * h) / sin_div[i];
      ss = q30(x * h);
      h = 64'sd1 << 30;
      for (int i = 0; i < 7; i++) h = (64'sd1 << 30) - q30(x2 * h) / cos_div[i];
      cc = h;
      if (ss < 0) ss = 0;
      if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
      if (cc < 0) cc = 0;
      if (cc > (64'sd1 << 30)) cc = 64'sd1 << 30;
      case (quad)
        evr_pkg::QUAD_0: begin s = ss; c = cc; end
        evr_pkg::QUAD_1: begin s = cc; c = -ss; end
        evr_pkg::QUAD_2: begin s = -ss; c = -cc; end
        default: begin s = -cc; c = ss; end
      endcase
    endfunction

    function logic signed [31:0] dot3(longint a0, longint a1, longint a2,
                                      longint r0, longint r1, longint r2);
      logic signed [127:0] acc;
      acc = 128'sd0;
      acc = acc + a0 * 128'(signed'(r0)) + 128'(signed'(a1)) * r1 + 128'(signed'(a2)) * r2;
      acc = (acc + 128'sd536870912) >>> 30;
      if (acc > 128'sd2147483647) acc = 128'sd2147483647;
      if (acc < -128'sd2147483648) acc = -128'sd2147483648;
      return acc[31:0];
    endfunction

    // Note an accepted input transfer and queue its rotated vector
    function void note_input(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic [15:0] p, logic [15:0] yw,
                             logic [15:0] r);
      longint sp, cp, sy, cy, sr, cr, t;
      longint m00, m01, m02, m10, m11, m12, m20, m21, m22, ax, ay, az;
      rot_vec_t e;
      ax = vx; ay = vy; az = vz;
      sin_cos(p, sp, cp);
      sin_cos(yw, sy, cy);
      sin_cos(r, sr, cr);
      m00 = q30(cp * cy); m01 = q30(cp * sy); m02 = -sp;
      t = q30(sr * sp);
      m10 = q30(t * cy) - q30(cr * sy);
      m11 = q30(t * sy) + q30(cr * cy);
      m12 = q30(sr * cp);
      t = q30(cr * sp);
      m20 = q30(t * cy) + q30(sr * sy);
      m21 = q30(t * sy) - q30(sr * cy);
      m22 = q30(cr * cp);
      e.x = dot3(ax, ay, az, m00, m01, m02);
      e.y = dot3(ax, ay, az, m10, m11, m12);
      e.z = dot3(ax, ay, az, m20, m21, m22);
      pending.push_back(e);
    endfunction

    // Check one output transfer against the oldest prediction
    function void check_result(logic signed [31:0] rx, logic signed [31:0] ry,
                               logic signed [31:0] rz);
      rot_vec_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0d %0d %0d", $time, rx, ry, rz);
        return;
      end
      e = pending.pop_front();
      matched++;
      if (rx !== e.x) begin
        errors++;
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, rx);
      end
      if (ry !== e.y) begin
        errors++;
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, ry);
      end
      if (rz !== e.z) begin
        errors++;
        $display("%0t: out_z expected %0d actual %0d", $time, e.z, rz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic [15:0] pitch = '0, yaw = '0, roll = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;

  rotation_scoreboard board = new();
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  euler_vector_rotate_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .pitch(pitch), .yaw(yaw), .roll(roll),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  always #10 clk = ~clk;

  // Check output transfers and draw the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_x, out_y, out_z);
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Drive one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz, logic [15:0] p, logic [15:0] yw,
                           logic [15:0] r);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_x <= vx; in_y <= vy; in_z <= vz;
    pitch <= p; yaw <= yw; roll <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(vx, vy, vz, p, yw, r);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom_range(131072) - 65536;
      1: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(4))
      0: return 16'($urandom_range(3) << 14) + 16'($urandom_range(2)) - 16'd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] quads[5];
    int gaps[4];
    int stalls[4];
    quads = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    gaps = '{0, 58, 0, 12};
    stalls = '{0, 0, 58, 12};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero vector, a fixed vector at quadrant angles, range extremes, saturation
    send_item(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++)
      send_item(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                quads[i], quads[(i + 1) % 5], quads[(i + 2) % 5]);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hE000, 16'h2000, 16'hA000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(-1, 1, -1, 16'h3FFF, 16'h7FFF, 16'hBFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h0001, 16'h4001, 16'h8001);

    // Random, over the idle and stall profiles
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gaps[ph];
      recv_stall_pct = stalls[ph];
      repeat (110) send_item(rand_comp(), rand_comp(), rand_comp(),
                             rand_angle(), rand_angle(), rand_angle());
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Rotated %0d vectors: quadrant and saturation cases, then random",
             board.matched);
    $display("data under four idle/stall profiles.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_euler_vector_rotate_core: clean");
    else
      $display("tb_euler_vector_rotate_core: errors");
    $finish;
  end

  // Bound the run
  initial begin
    #4ms;
    $display("tb_euler_vector_rotate_core: errors");
    $finish;
  end
endmodule
